// ===== rtl/tsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types and constants of the triangle scanline fill block.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 32;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic load;       // capture and sort a triangle
    logic mul;        // form edge products and divisors
    logic div_start;  // launch both dividers
    logic fin;        // build span, advance row
  } cmd_t;

  typedef struct packed {
    logic active;     // a triangle has spans left
    logic div_done;
  } status_t;

endpackage

// ===== rtl/triangle_scanline_fill.sv =====
// ----------------------------------------------------------------------------
// triangle_scanline_fill
// Scanline triangle fill: load a triangle, then pull one span per step.
// ----------------------------------------------------------------------------
// A load beat (in_op = 0) yields nothing; a triangle with
// all y equal is dropped. Each step beat (in_op = 1) while spans remain
// yields one span on out_* with out_valid high for one cycle, after
// both edge divisions have run in a pair of serial dividers, one quotient
// bit per cycle. busy is high while they run, so the next step is taken
// at the edge that takes the span.
// A step with no spans left is taken and ignored.
// The receiver cannot stall; every span must be taken when out_valid is high.
module triangle_scanline_fill #(
  parameter int COORD_BITS = tsf_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [COORD_BITS-1:0]        in_first_x,
  input  logic signed [COORD_BITS-1:0]        in_first_y,
  input  logic signed [COORD_BITS-1:0]        in_second_x,
  input  logic signed [COORD_BITS-1:0]        in_second_y,
  input  logic signed [COORD_BITS-1:0]        in_third_x,
  input  logic signed [COORD_BITS-1:0]        in_third_y,
  input  logic [tsf_pkg::COLOR_BITS-1:0]      in_fill_color,
  output logic                                out_valid,
  output logic signed [COORD_BITS-1:0]        out_span_y,
  output logic signed [COORD_BITS-1:0]        out_span_left,
  output logic signed [COORD_BITS-1:0]        out_span_right,
  output logic [tsf_pkg::COLOR_BITS-1:0]      out_span_color,
  output logic                                out_last_span
);

  tsf_pkg::cmd_t    cmd;
  tsf_pkg::status_t status;

  tsf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_op),
    .status(status), .cmd(cmd), .busy(busy)
  );

  tsf_datapath #(.W(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .v0_x(in_first_x), .v0_y(in_first_y),
    .v1_x(in_second_x), .v1_y(in_second_y),
    .v2_x(in_third_x), .v2_y(in_third_y),
    .color(in_fill_color),
    .span_valid(out_valid), .span_y(out_span_y),
    .span_left(out_span_left), .span_right(out_span_right),
    .span_color(out_span_color), .span_last(out_last_span)
  );

endmodule

// ===== rtl/tsf_div.sv =====
// ----------------------------------------------------------------------------
// tsf_div
// Serial restoring divider, one quotient bit per cycle. The quotient is known
// to fit in W bits (dividend below divisor * 2**W).
// ----------------------------------------------------------------------------
module tsf_div #(
  parameter int W = tsf_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic [W-1:0]   quotient,
  output logic           done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dq_r, dq_nxt;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    trial    = {rem_r, dq_r[W-1]};
    diff     = trial - {1'b0, dsr_r};
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend[2*W-1:W];
      dq_nxt  = dividend[W-1:0];
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        dq_nxt  = {dq_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        dq_nxt  = {dq_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    if (start) dsr_r <= divisor;
  end

  assign quotient = dq_r;
  assign done     = done_r;

endmodule

// ===== rtl/tsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsf_ctrl
// Sequencer: accepts commands, steps the datapath through one span.
// ----------------------------------------------------------------------------
module tsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              op,
  input  tsf_pkg::status_t  status,
  output tsf_pkg::cmd_t     cmd,
  output logic              busy
);

  tsf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tsf_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      tsf_pkg::ST_IDLE: begin
        if (start) begin
          if (op == tsf_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (status.active) begin
            cmd.mul   = 1'b1;
            state_nxt = tsf_pkg::ST_DIV_GO;
          end
        end
      end
      tsf_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = tsf_pkg::ST_DIV;
      end
      tsf_pkg::ST_DIV: begin
        if (status.div_done) begin
          cmd.fin   = 1'b1;
          state_nxt = tsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsf_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != tsf_pkg::ST_IDLE);

endmodule

// ===== rtl/tsf_datapath.sv =====
// ----------------------------------------------------------------------------
// tsf_datapath
// Vertex sort, edge products, two serial dividers and span assembly.
// ----------------------------------------------------------------------------
module tsf_datapath #(
  parameter int W = tsf_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tsf_pkg::cmd_t                    cmd,
  output tsf_pkg::status_t                 status,
  input  logic signed [W-1:0]              v0_x,
  input  logic signed [W-1:0]              v0_y,
  input  logic signed [W-1:0]              v1_x,
  input  logic signed [W-1:0]              v1_y,
  input  logic signed [W-1:0]              v2_x,
  input  logic signed [W-1:0]              v2_y,
  input  logic [tsf_pkg::COLOR_BITS-1:0]   color,
  output logic                             span_valid,
  output logic signed [W-1:0]              span_y,
  output logic signed [W-1:0]              span_left,
  output logic signed [W-1:0]              span_right,
  output logic [tsf_pkg::COLOR_BITS-1:0]   span_color,
  output logic                             span_last
);

  logic signed [W-1:0] lx_r, ly_r, mx_r, my_r, hx_r, hy_r;
  logic [W:0]          row_r;
  logic [tsf_pkg::COLOR_BITS-1:0] color_r;
  logic                active_r;

  // sort network: (0,1), (0,2), (1,2), strict compares
  logic signed [W-1:0] ax, ay, bx, by, cx, cy, tx, ty;
  logic                flat;

  always_comb begin
    ax = v0_x; ay = v0_y; bx = v1_x; by = v1_y; cx = v2_x; cy = v2_y;
    tx = '0; ty = '0;
    flat = (v0_y == v1_y) && (v0_y == v2_y);
    if (ay > by) begin
      tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
    end
    if (ay > cy) begin
      tx = ax; ty = ay; ax = cx; ay = cy; cx = tx; cy = ty;
    end
    if (by > cy) begin
      tx = bx; ty = by; bx = cx; by = cy; cx = tx; cy = ty;
    end
  end

  // edge products
  logic signed [W:0]     tot, h1, seg, i_s, j_s, dxa, dxb;
  logic signed [2*W+1:0] pa, pb;
  logic                  second;

  always_comb begin
    tot    = {hy_r[W-1], hy_r} - {ly_r[W-1], ly_r};
    h1     = {my_r[W-1], my_r} - {ly_r[W-1], ly_r};
    seg    = {hy_r[W-1], hy_r} - {my_r[W-1], my_r};
    i_s    = $signed(row_r);
    second = (i_s > h1) || (h1 == '0);
    j_s    = second ? (i_s - h1) : i_s;
    dxa    = {hx_r[W-1], hx_r} - {lx_r[W-1], lx_r};
    dxb    = second ? ({hx_r[W-1], hx_r} - {mx_r[W-1], mx_r})
                    : ({mx_r[W-1], mx_r} - {lx_r[W-1], lx_r});
    pa     = dxa * i_s;
    pb     = dxb * j_s;
  end

  logic [2*W-1:0]      mag_a_r, mag_b_r;
  logic                neg_a_r, neg_b_r;
  logic [W-1:0]        dsr_a_r, dsr_b_r;
  logic signed [W-1:0] base_b_r;
  logic                last_r;
  logic [2*W+1:0]      abs_a, abs_b;

  assign abs_a = pa[2*W+1] ? -pa : pa;
  assign abs_b = pb[2*W+1] ? -pb : pb;

  logic [W-1:0] qa, qb;
  logic         done_a, done_b;

  tsf_div #(.W(W)) u_div_a (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(mag_a_r), .divisor(dsr_a_r), .quotient(qa), .done(done_a)
  );

  tsf_div #(.W(W)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(mag_b_r), .divisor(dsr_b_r), .quotient(qb), .done(done_b)
  );

  // span assembly
  logic signed [W+1:0] sa, sb, xa_full, xb_full;
  logic signed [W-1:0] xa, xb;
  logic [W:0]          row_y;

  always_comb begin
    sa      = neg_a_r ? -$signed({2'b00, qa}) : $signed({2'b00, qa});
    sb      = neg_b_r ? -$signed({2'b00, qb}) : $signed({2'b00, qb});
    xa_full = {{2{lx_r[W-1]}}, lx_r} + sa;
    xb_full = {{2{base_b_r[W-1]}}, base_b_r} + sb;
    xa      = xa_full[W-1:0];
    xb      = xb_full[W-1:0];
    row_y   = {ly_r[W-1], ly_r} + row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r <= '0; ly_r <= '0; mx_r <= '0; my_r <= '0; hx_r <= '0; hy_r <= '0;
      row_r      <= '0;
      color_r    <= '0;
      active_r   <= 1'b0;
      span_valid <= 1'b0;
    end else begin
      span_valid <= cmd.fin;
      if (cmd.load) begin
        if (flat) begin
          active_r <= 1'b0;
        end else begin
          lx_r <= ax; ly_r <= ay; mx_r <= bx; my_r <= by; hx_r <= cx; hy_r <= cy;
          color_r  <= color;
          row_r    <= '0;
          active_r <= 1'b1;
        end
      end
      if (cmd.fin) begin
        if (last_r) active_r <= 1'b0;
        else        row_r    <= row_r + (W+1)'(1);
      end
    end
    if (cmd.mul) begin
      mag_a_r  <= abs_a[2*W-1:0];
      mag_b_r  <= abs_b[2*W-1:0];
      neg_a_r  <= pa[2*W+1];
      neg_b_r  <= pb[2*W+1];
      dsr_a_r  <= tot[W-1:0];
      dsr_b_r  <= second ? seg[W-1:0] : h1[W-1:0];
      base_b_r <= second ? mx_r : lx_r;
      last_r   <= ((i_s + (W+1)'(1)) >= tot);
    end
    if (cmd.fin) begin
      span_y     <= row_y[W-1:0];
      span_left  <= (xa < xb) ? xa : xb;
      span_right <= (xa < xb) ? xb : xa;
      span_color <= color_r;
      span_last  <= last_r;
    end
  end

  assign status.active   = active_r;
  assign status.div_done = done_a & done_b;

endmodule

// ===== rtl/tsf_checker.sv =====
// ----------------------------------------------------------------------------
// tsf_checker
// Port-level checks of the triangle scanline fill block.
// ----------------------------------------------------------------------------
module tsf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_op,
  input logic out_valid
);

  // a span is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held more than one cycle");

  // span beat ends a busy period
  a_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("span without preceding busy period");

  // only a step beat starts work
  a_rise_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_op == tsf_pkg::OP_STEP))
    else $error("busy without a step beat");

  // a load beat never starts work
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == tsf_pkg::OP_LOAD) |=> !busy)
    else $error("load beat made block busy");

endmodule

bind triangle_scanline_fill tsf_checker u_tsf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_op(in_op), .out_valid(out_valid)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of triangle_scanline_fill: loads and steps are driven as command
// beats; each span is checked against a scanline predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = tsf_pkg::COORD_BITS_DEF;
  localparam int CB        = tsf_pkg::COLOR_BITS;
  localparam int DRAIN     = 40;
  localparam int MAX_CYCLE = 2000000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    tsf_pkg::op_t          op;
    coord_t                x0, y0, x1, y1, x2, y2;
    logic [CB-1:0]         color;
  } beat_t;

  typedef struct {
    coord_t                y, left, right;
    logic [CB-1:0]         color;
    logic                  last;
  } span_t;

  typedef struct { longint x, y; } pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  coord_t in_first_x = '0, in_first_y = '0, in_second_x = '0;
  coord_t in_second_y = '0, in_third_x = '0, in_third_y = '0;
  logic [CB-1:0] in_fill_color = '0;
  logic out_valid;
  coord_t out_span_y, out_span_left, out_span_right;
  logic [CB-1:0] out_span_color;
  logic out_last_span;

  triangle_scanline_fill u_top (
    .clk, .rst_n, .start, .busy, .in_op,
    .in_first_x, .in_first_y, .in_second_x, .in_second_y,
    .in_third_x, .in_third_y, .in_fill_color,
    .out_valid, .out_span_y, .out_span_left, .out_span_right,
    .out_span_color, .out_last_span
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // scanline state
  pt_t   tri_lo, tri_mid, tri_hi;
  longint row_cnt;
  logic [CB-1:0] tri_color;
  bit    tri_active;

  span_t span_q[$];
  int    err_cnt;
  int    idle_pct;
  longint cycle_cnt;

  function automatic void sort_pair(ref pt_t a, ref pt_t b);
    pt_t t;
    if (a.y > b.y) begin
      t = a; a = b; b = t;
    end
  endfunction

  function automatic void scan_predict(beat_t b);
    pt_t a, m, c;
    longint total, h1, ax, bx;
    span_t s;
    if (b.op == tsf_pkg::OP_LOAD) begin
      a.x = b.x0; a.y = b.y0; m.x = b.x1; m.y = b.y1; c.x = b.x2; c.y = b.y2;
      if (a.y == m.y && a.y == c.y) begin
        tri_active = 0;
        return;
      end
      sort_pair(a, m);
      sort_pair(a, c);
      sort_pair(m, c);
      tri_lo = a; tri_mid = m; tri_hi = c;
      tri_color = b.color;
      row_cnt = 0;
      tri_active = 1;
      return;
    end
    if (!tri_active) return;
    total = tri_hi.y - tri_lo.y;
    h1 = tri_mid.y - tri_lo.y;
    ax = tri_lo.x + ((tri_hi.x - tri_lo.x) * row_cnt) / total;
    if (row_cnt > h1 || h1 == 0)
      bx = tri_mid.x + ((tri_hi.x - tri_mid.x) * (row_cnt - h1)) / (tri_hi.y - tri_mid.y);
    else
      bx = tri_lo.x + ((tri_mid.x - tri_lo.x) * row_cnt) / h1;
    s.y = coord_t'(tri_lo.y + row_cnt);
    s.left = coord_t'(ax < bx ? ax : bx);
    s.right = coord_t'(ax < bx ? bx : ax);
    s.color = tri_color;
    s.last = (row_cnt + 1 >= total);
    if (s.last) tri_active = 0;
    else row_cnt++;
    span_q.push_back(s);
  endfunction

  // start stays high across back-to-back beats; only a gap lowers it
  task automatic send_beat(beat_t b);
    in_op <= b.op;
    in_first_x <= b.x0; in_first_y <= b.y0;
    in_second_x <= b.x1; in_second_y <= b.y1;
    in_third_x <= b.x2; in_third_y <= b.y2;
    in_fill_color <= b.color;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    scan_predict(b);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic load_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                          logic [CB-1:0] color);
    beat_t b;
    b.op = tsf_pkg::OP_LOAD;
    b.x0 = coord_t'(x0); b.y0 = coord_t'(y0); b.x1 = coord_t'(x1);
    b.y1 = coord_t'(y1); b.x2 = coord_t'(x2); b.y2 = coord_t'(y2);
    b.color = color;
    send_beat(b);
  endtask

  task automatic step_n(int n);
    beat_t b;
    b.op = tsf_pkg::OP_STEP;
    for (int k = 0; k < n; k++) begin
      b.x0 = coord_t'($urandom); b.y0 = coord_t'($urandom); b.x1 = coord_t'($urandom);
      b.y1 = coord_t'($urandom); b.x2 = coord_t'($urandom); b.y2 = coord_t'($urandom);
      b.color = $urandom;
      send_beat(b);
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    step_n(1);                                         // step while idle
    load_tri(-2048, -2048, 2047, 2047, -2048, 0, '1); // full height, extreme x
    step_n(300);                                       // upper rows; next load drops the rest
    load_tri(5, 0, 1, 0, 9, 3, '0);                    // flat top, equal-y tie
    step_n(3);
    load_tri(0, 0, 4, 5, -3, 5, 32'h5a5a_a5a5);        // flat bottom
    step_n(5);
    load_tri(2047, 10, -2048, 2, 0, -6, 32'h1234_5678);
    step_n(2);
    load_tri(7, 3, 7, 3, 7, 3, 32'hdead_beef);         // flat load while spans remain
    step_n(1);
    load_tri(1, 1, 100, 40, -100, 20, 32'hffff_0000);
    step_n(3);
    load_tri(-5, 9, 3, 1, 0, 4, 32'h0000_ffff);        // load while spans remain
    step_n(9);
  endtask

  task automatic test_random(int pct, int n_beats);
    int sent, h, base, extra;
    int y[3];
    idle_pct = pct;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise: stray step or a broken sequence
        step_n(1);
        sent++;
        continue;
      end
      if ($urandom_range(0, 99) < 90) begin
        h = $urandom_range(0, 12);
        base = $urandom_range(0, 4095 - 12) - 2048;
        foreach (y[k]) y[k] = base + $urandom_range(0, h);
        if ($urandom_range(0, 99) < 4) y[1] = y[0];
        if ($urandom_range(0, 99) < 4) y[2] = y[0];
      end else begin
        foreach (y[k]) y[k] = $urandom_range(0, 4095) - 2048;
      end
      load_tri($urandom_range(0, 4095) - 2048, y[0], $urandom_range(0, 4095) - 2048,
               y[1], $urandom_range(0, 4095) - 2048, y[2], $urandom);
      sent++;
      h = tri_active ? int'(tri_hi.y - tri_lo.y) : 0;
      extra = $urandom_range(0, 2);
      if (h > 20) h = $urandom_range(0, 20);                // cut short, next load drops it
      else if ($urandom_range(0, 9) == 0) h = $urandom_range(0, h);
      step_n(h + extra);
      sent += h + extra;
    end
  endtask

  always @(posedge clk) begin
    span_t e;
    if (rst_n && out_valid) begin
      if (span_q.size() == 0) begin
        $display("%0t unexpected span y %0d", $time, out_span_y);
        err_cnt++;
      end else begin
        e = span_q.pop_front();
        if (out_span_y !== e.y) begin
          $display("%0t span_y exp %0d got %0d", $time, e.y, out_span_y); err_cnt++;
        end
        if (out_span_left !== e.left) begin
          $display("%0t span_left exp %0d got %0d", $time, e.left, out_span_left); err_cnt++;
        end
        if (out_span_right !== e.right) begin
          $display("%0t span_right exp %0d got %0d", $time, e.right, out_span_right); err_cnt++;
        end
        if (out_span_color !== e.color) begin
          $display("%0t span_color exp %h got %h", $time, e.color, out_span_color); err_cnt++;
        end
        if (out_last_span !== e.last) begin
          $display("%0t last_span exp %0b got %0b", $time, e.last, out_last_span); err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    err_cnt = 0;
    cycle_cnt = 0;
    idle_pct = 0;
    tri_active = 0;
    row_cnt = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0, 350);
    test_random(82, 350);
    test_random(0, 350);
    test_random(15, 350);
    start <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_cnt == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/tsf_pkg.sv
rtl/tsf_div.sv
rtl/tsf_ctrl.sv
rtl/tsf_datapath.sv
rtl/triangle_scanline_fill.sv
rtl/tsf_checker.sv
dv/tb_top.sv
